[src/priority_table_increase_key_assert.svh]
// Assertion macros for the priority table block.
// PTIK_ASSERT checks a property on the rising clock edge, disabled during reset.
// PTIK_ASSERT_IMP checks an implication on the rising clock edge, disabled during reset.
`ifndef PRIORITY_TABLE_INCREASE_KEY_ASSERT_SVH
`define PRIORITY_TABLE_INCREASE_KEY_ASSERT_SVH
`ifndef SYNTHESIS
`define PTIK_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PTIK_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define PTIK_ASSERT(lbl, prop, msg)
`define PTIK_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

[src/ptik_pkg.sv]
`timescale 1ns / 1ps

package ptik_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int ACT_W    = 3;
    localparam int ID_W     = 6;
    localparam int DATA_W   = 32;
    localparam int PRIO_W   = 31;
    localparam int ORDER_W  = 32;
    localparam int STATUS_W = 2;

    localparam logic [ACT_W-1:0] ACT_ADD      = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PROMOTE  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_GET_MAX  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_POP_MAX  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_IS_VALID = 3'd4;
    localparam logic [ACT_W-1:0] ACT_GET      = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_ID  = 2'd3;

    localparam logic [PRIO_W-1:0] PRIO_MAX = '1;

    // write command into the entry stores
    typedef struct packed {
        logic               en_all;
        logic               en_prio;
        logic [PRIO_W-1:0]  prio;
        logic [DATA_W-1:0]  payload;
        logic [ORDER_W-1:0] tag;
    } ptik_wr_t;

    // one entry as read back from the stores
    typedef struct packed {
        logic [PRIO_W-1:0]  prio;
        logic [DATA_W-1:0]  payload;
        logic [ORDER_W-1:0] tag;
    } ptik_rd_t;

endpackage

[src/ptik_if.sv]
`timescale 1ns / 1ps

interface ptik_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [ptik_pkg::ACT_W-1:0]    action;
    logic [ptik_pkg::ID_W-1:0]     entry_id;
    logic [ptik_pkg::DATA_W-1:0]   payload;

    modport source (output valid, action, entry_id, payload, input ready);
    modport sink   (input valid, action, entry_id, payload, output ready);
endinterface

interface ptik_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ptik_pkg::STATUS_W-1:0] status;
    logic [ptik_pkg::ID_W-1:0]     result_id;
    logic [ptik_pkg::DATA_W-1:0]   result_payload;
    logic [ptik_pkg::PRIO_W-1:0]   result_priority;
    logic                          id_is_valid;

    modport source (output valid, status, result_id, result_payload, result_priority,
                    id_is_valid, input ready);
    modport sink   (input valid, status, result_id, result_payload, result_priority,
                    id_is_valid, output ready);
endinterface

[src/ptik_cmp.sv]
`timescale 1ns / 1ps

module ptik_cmp (
    input  logic [ptik_pkg::PRIO_W-1:0]  cand_prio,
    input  logic [ptik_pkg::ORDER_W-1:0] cand_tag,
    input  logic [ptik_pkg::PRIO_W-1:0]  best_prio,
    input  logic [ptik_pkg::ORDER_W-1:0] best_tag,
    output logic                         gt
);
    import ptik_pkg::*;

    // strictly greater: on a full tie the earlier (lower) slot keeps the lead
    always_comb
    begin
        gt = (cand_prio > best_prio) ||
             ((cand_prio == best_prio) && (cand_tag > best_tag));
    end

endmodule

[src/ptik_store.sv]
`timescale 1ns / 1ps

module ptik_store #(
    parameter int CAPACITY = ptik_pkg::CAPACITY_DEF,
    parameter int IDX_W    = $clog2(CAPACITY)
) (
    input  logic               clk,
    input  ptik_pkg::ptik_wr_t wr,
    input  logic [IDX_W-1:0]   wr_addr,
    input  logic [IDX_W-1:0]   rd_addr,
    output ptik_pkg::ptik_rd_t rd
);
    import ptik_pkg::*;

    logic [PRIO_W-1:0]  prio_mem [CAPACITY];
    logic [DATA_W-1:0]  data_mem [CAPACITY];
    logic [ORDER_W-1:0] tag_mem  [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (wr.en_all)
        begin
            prio_mem[wr_addr] <= wr.prio;
            data_mem[wr_addr] <= wr.payload;
            tag_mem[wr_addr]  <= wr.tag;
        end
        else if (wr.en_prio)
        begin
            prio_mem[wr_addr] <= wr.prio;
        end
    end

    always_ff @(posedge clk)
    begin
        rd.prio    <= prio_mem[rd_addr];
        rd.payload <= data_mem[rd_addr];
        rd.tag     <= tag_mem[rd_addr];
    end

endmodule

[src/priority_table_increase_key.sv]
// Priority table of CAPACITY slots with increase-key. One command transfer in gives one
// response transfer out; commands are taken one at a time. Add scans the live map for the
// lowest free slot, one slot per cycle. GetMax and PopMax stream every slot through the
// single entry-store read port into one priority/tag comparator. Promote, Get, IsValid and
// unused codes go straight to completion without a scan. The response register lets the
// next command be taken while a response waits. No clearing pass runs after reset; the live
// map is cleared at once.
`timescale 1ns / 1ps
`include "priority_table_increase_key_assert.svh"

module priority_table_increase_key #(
    parameter int CAPACITY = ptik_pkg::CAPACITY_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    ptik_cmd_if.sink   cmd,
    ptik_rsp_if.source rsp
);
    import ptik_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic [ACT_W-1:0]     act_reg, act_next;
    logic [IDX_W-1:0]     slot_reg, slot_next;
    logic [ID_W-1:0]      id_reg, id_next;
    logic [DATA_W-1:0]    pl_reg, pl_next;
    logic                 ok_reg, ok_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic                 pend_reg, pend_next;
    logic [IDX_W-1:0]     pend_idx_reg, pend_idx_next;
    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic [PRIO_W-1:0]    best_prio_reg, best_prio_next;
    logic [ORDER_W-1:0]   best_tag_reg, best_tag_next;
    logic [DATA_W-1:0]    best_pl_reg, best_pl_next;
    logic [CAPACITY-1:0]  live_reg, live_next;
    logic [ORDER_W-1:0]   tag_cnt_reg, tag_cnt_next;

    logic                 out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]  out_status_reg, out_status_next;
    logic [ID_W-1:0]      out_id_reg, out_id_next;
    logic [DATA_W-1:0]    out_pl_reg, out_pl_next;
    logic [PRIO_W-1:0]    out_prio_reg, out_prio_next;
    logic                 out_live_reg, out_live_next;

    ptik_wr_t             wr;
    logic [IDX_W-1:0]     wr_addr;
    logic [IDX_W-1:0]     rd_addr;
    ptik_rd_t             rd;
    logic                 gt;
    logic                 take;
    logic                 out_free;
    logic                 cmd_xfer;
    logic [IDX_W-1:0]     cmd_slot;
    logic                 cmd_in_range;

    ptik_store #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W)
    ) u_store (
        .clk     (clk),
        .wr      (wr),
        .wr_addr (wr_addr),
        .rd_addr (rd_addr),
        .rd      (rd)
    );

    ptik_cmp u_cmp (
        .cand_prio (rd.prio),
        .cand_tag  (rd.tag),
        .best_prio (best_prio_reg),
        .best_tag  (best_tag_reg),
        .gt        (gt)
    );

    assign cmd.ready    = (state_reg == S_IDLE);
    assign cmd_xfer     = cmd.valid && cmd.ready;
    assign cmd_slot     = IDX_W'(cmd.entry_id);
    assign cmd_in_range = (32'(cmd.entry_id) < 32'(CAPACITY));
    assign out_free     = !out_valid_reg || rsp.ready;
    assign take         = pend_reg && live_reg[pend_idx_reg] && (!found_reg || gt);

    always_comb
    begin
        case (state_reg)
            S_IDLE:  rd_addr = cmd_slot;
            S_SCAN:  rd_addr = idx_reg[IDX_W-1:0];
            default: rd_addr = slot_reg;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        act_next        = act_reg;
        slot_next       = slot_reg;
        id_next         = id_reg;
        pl_next         = pl_reg;
        ok_next         = ok_reg;
        idx_next        = idx_reg;
        pend_next       = 1'b0;
        pend_idx_next   = pend_idx_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_prio_next  = best_prio_reg;
        best_tag_next   = best_tag_reg;
        best_pl_next    = best_pl_reg;
        live_next       = live_reg;
        tag_cnt_next    = tag_cnt_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_pl_next     = out_pl_reg;
        out_prio_next   = out_prio_reg;
        out_live_next   = out_live_reg;
        wr              = '0;
        wr_addr         = slot_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_xfer)
                begin
                    act_next   = cmd.action;
                    slot_next  = cmd_slot;
                    id_next    = cmd.entry_id;
                    pl_next    = cmd.payload;
                    ok_next    = cmd_in_range && live_reg[cmd_slot];
                    idx_next   = '0;
                    found_next = 1'b0;
                    case (cmd.action)
                        ACT_ADD, ACT_GET_MAX, ACT_POP_MAX: state_next = S_SCAN;
                        default:                           state_next = S_DONE;
                    endcase
                end
            end

            S_SCAN:
            begin
                if (act_reg == ACT_ADD)
                begin
                    if (idx_reg == CNT_END)
                    begin
                        state_next = S_DONE;
                    end
                    else if (!live_reg[idx_reg[IDX_W-1:0]])
                    begin
                        found_next    = 1'b1;
                        best_idx_next = idx_reg[IDX_W-1:0];
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    if (idx_reg != CNT_END)
                    begin
                        pend_next     = 1'b1;
                        pend_idx_next = idx_reg[IDX_W-1:0];
                        idx_next      = idx_reg + 1'b1;
                    end
                    if (take)
                    begin
                        found_next     = 1'b1;
                        best_idx_next  = pend_idx_reg;
                        best_prio_next = rd.prio;
                        best_tag_next  = rd.tag;
                        best_pl_next   = rd.payload;
                    end
                    if (idx_reg == CNT_END && !pend_reg)
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    state_next      = S_IDLE;
                    out_valid_next  = 1'b1;
                    out_status_next = ST_OK;
                    out_id_next     = '0;
                    out_pl_next     = '0;
                    out_prio_next   = '0;
                    out_live_next   = 1'b0;
                    case (act_reg)
                        ACT_ADD:
                        begin
                            if (found_reg)
                            begin
                                wr.en_all  = 1'b1;
                                wr.prio    = '0;
                                wr.payload = pl_reg;
                                wr.tag     = tag_cnt_reg;
                                wr_addr    = best_idx_reg;
                                live_next[best_idx_reg] = 1'b1;
                                tag_cnt_next = tag_cnt_reg + 1'b1;
                                out_id_next  = ID_W'(best_idx_reg);
                            end
                            else
                            begin
                                out_status_next = ST_FULL;
                            end
                        end
                        ACT_PROMOTE:
                        begin
                            out_id_next = id_reg;
                            if (ok_reg)
                            begin
                                wr.en_prio    = 1'b1;
                                wr.prio       = (rd.prio == PRIO_MAX) ? rd.prio
                                                                      : rd.prio + 1'b1;
                                out_prio_next = wr.prio;
                            end
                            else
                            begin
                                out_status_next = ST_BAD_ID;
                            end
                        end
                        ACT_GET_MAX, ACT_POP_MAX:
                        begin
                            if (found_reg)
                            begin
                                out_id_next   = ID_W'(best_idx_reg);
                                out_pl_next   = best_pl_reg;
                                out_prio_next = best_prio_reg;
                                if (act_reg == ACT_POP_MAX)
                                begin
                                    live_next[best_idx_reg] = 1'b0;
                                end
                            end
                            else
                            begin
                                out_status_next = ST_EMPTY;
                            end
                        end
                        ACT_IS_VALID:
                        begin
                            out_id_next   = id_reg;
                            out_live_next = ok_reg;
                        end
                        ACT_GET:
                        begin
                            out_id_next = id_reg;
                            if (ok_reg)
                            begin
                                out_pl_next = rd.payload;
                            end
                            else
                            begin
                                out_status_next = ST_BAD_ID;
                            end
                        end
                        default:
                        begin
                            out_status_next = ST_OK;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            act_reg       <= ACT_ADD;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            idx_reg       <= '0;
            live_reg      <= '0;
            tag_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            act_reg       <= act_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            idx_reg       <= idx_next;
            live_reg      <= live_next;
            tag_cnt_reg   <= tag_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg       <= slot_next;
        id_reg         <= id_next;
        pl_reg         <= pl_next;
        ok_reg         <= ok_next;
        pend_idx_reg   <= pend_idx_next;
        best_idx_reg   <= best_idx_next;
        best_prio_reg  <= best_prio_next;
        best_tag_reg   <= best_tag_next;
        best_pl_reg    <= best_pl_next;
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
        out_pl_reg     <= out_pl_next;
        out_prio_reg   <= out_prio_next;
        out_live_reg   <= out_live_next;
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_status_reg;
    assign rsp.result_id       = out_id_reg;
    assign rsp.result_payload  = out_pl_reg;
    assign rsp.result_priority = out_prio_reg;
    assign rsp.id_is_valid     = out_live_reg;

    `PTIK_ASSERT_IMP(a_rsp_from_done, $rose(out_valid_reg), $past(state_reg == S_DONE),
                     "response raised outside completion")
    `PTIK_ASSERT(a_idx_bound, idx_reg <= CNT_END, "scan index past table end")
    `PTIK_ASSERT_IMP(a_best_live,
                     (state_reg == S_SCAN) && (act_reg != ACT_ADD) && found_reg,
                     live_reg[best_idx_reg], "max candidate not live")
    `PTIK_ASSERT_IMP(a_tag_on_add, tag_cnt_reg != $past(tag_cnt_reg),
                     $past((state_reg == S_DONE) && (act_reg == ACT_ADD) && found_reg && out_free),
                     "order tag moved without an add")
    `PTIK_ASSERT_IMP(a_add_free, (state_reg == S_DONE) && (act_reg == ACT_ADD) && found_reg,
                     !live_reg[best_idx_reg], "add targets a live slot")

endmodule

[sim/tb_priority_table_increase_key.sv]
`timescale 1ns / 1ps

module tb_priority_table_increase_key;
    import ptik_pkg::*;

    localparam int NUM_SLOTS   = CAPACITY_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASE_ITEMS = 515;
    localparam int TAIL_CYCLES = 2 * NUM_SLOTS + 20;

    // unused action codes
    localparam logic [ACT_W-1:0] ACT_SPARE_6 = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [ID_W-1:0]   entry_id;
        logic [DATA_W-1:0] payload;
        logic              hold;
    } table_cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     result_id;
        logic [DATA_W-1:0]   result_payload;
        logic [PRIO_W-1:0]   result_priority;
        logic                id_is_valid;
    } table_rsp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ptik_cmd_if cmd ();
    ptik_rsp_if rsp ();

    priority_table_increase_key #(
        .CAPACITY(NUM_SLOTS)
    ) uut (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd),
        .rsp  (rsp)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    table_cmd_t cmd_pending_q[$];
    table_rsp_t rsp_expected_q[$];

    // shadow of the table contents
    bit                slot_live[NUM_SLOTS];
    logic [PRIO_W-1:0] slot_prio[NUM_SLOTS];
    logic [DATA_W-1:0] slot_data[NUM_SLOTS];
    logic [ORDER_W-1:0] slot_tag[NUM_SLOTS];
    logic [ORDER_W-1:0] tag_next;

    int  send_idle_pct;
    int  recv_idle_pct;
    int  err_cnt;
    int  cycle_cnt;
    int  n_cmds;
    int  n_rsps;
    int  n_full;
    int  n_empty;
    int  n_bad_id;
    int  live_count;
    bit  hold_next;
    bit  cmd_fire;

    task automatic table_apply(input table_cmd_t c, output table_rsp_t r);
        int  k;
        int  best;
        bit  hit;
        r   = '0;
        hit = slot_live[c.entry_id];
        case (c.action)
            ACT_ADD:
            begin
                k = -1;
                for (int i = NUM_SLOTS - 1; i >= 0; i--)
                    if (!slot_live[i])
                        k = i;
                if (k < 0)
                    r.status = ST_FULL;
                else
                begin
                    slot_live[k] = 1'b1;
                    slot_prio[k] = '0;
                    slot_data[k] = c.payload;
                    slot_tag[k]  = tag_next;
                    tag_next     = tag_next + 1'b1;
                    r.result_id  = k[ID_W-1:0];
                end
            end
            ACT_PROMOTE:
            begin
                r.result_id = c.entry_id;
                if (!hit)
                    r.status = ST_BAD_ID;
                else
                begin
                    if (slot_prio[c.entry_id] != PRIO_MAX)
                        slot_prio[c.entry_id] = slot_prio[c.entry_id] + 1'b1;
                    r.result_priority = slot_prio[c.entry_id];
                end
            end
            ACT_GET_MAX, ACT_POP_MAX:
            begin
                best = -1;
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (slot_live[i])
                    begin
                        if (best < 0 || slot_prio[i] > slot_prio[best] ||
                            (slot_prio[i] == slot_prio[best] && slot_tag[i] > slot_tag[best]))
                            best = i;
                    end
                end
                if (best < 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.result_id       = best[ID_W-1:0];
                    r.result_payload  = slot_data[best];
                    r.result_priority = slot_prio[best];
                    if (c.action == ACT_POP_MAX)
                        slot_live[best] = 1'b0;
                end
            end
            ACT_IS_VALID:
            begin
                r.result_id   = c.entry_id;
                r.id_is_valid = hit;
            end
            ACT_GET:
            begin
                r.result_id = c.entry_id;
                if (!hit)
                    r.status = ST_BAD_ID;
                else
                    r.result_payload = slot_data[c.entry_id];
            end
            default: ;
        endcase
    endtask

    task automatic check_rsp(input table_rsp_t want, input table_rsp_t got);
        if (got.status != want.status)
        begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            err_cnt++;
        end
        if (got.result_id != want.result_id)
        begin
            $error("result_id: expected %0d, actual %0d", want.result_id, got.result_id);
            err_cnt++;
        end
        if (got.result_payload != want.result_payload)
        begin
            $error("result_payload: expected %h, actual %h",
                   want.result_payload, got.result_payload);
            err_cnt++;
        end
        if (got.result_priority != want.result_priority)
        begin
            $error("result_priority: expected %0d, actual %0d",
                   want.result_priority, got.result_priority);
            err_cnt++;
        end
        if (got.id_is_valid != want.id_is_valid)
        begin
            $error("id_is_valid: expected %0d, actual %0d", want.id_is_valid, got.id_is_valid);
            err_cnt++;
        end
    endtask

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // sample transfers on both channels
    always @(posedge clk)
    begin : sample
        table_cmd_t c;
        table_rsp_t r;
        table_rsp_t got;
        cmd_fire = rst_n && cmd.valid && cmd.ready;
        if (cmd_fire)
        begin
            c.action   = cmd.action;
            c.entry_id = cmd.entry_id;
            c.payload  = cmd.payload;
            c.hold     = 1'b0;
            table_apply(c, r);
            rsp_expected_q.insert(rsp_expected_q.size(), r);
            n_cmds++;
        end
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got.status          = rsp.status;
            got.result_id       = rsp.result_id;
            got.result_payload  = rsp.result_payload;
            got.result_priority = rsp.result_priority;
            got.id_is_valid     = rsp.id_is_valid;
            n_rsps++;
            case (got.status)
                ST_FULL:   n_full++;
                ST_EMPTY:  n_empty++;
                ST_BAD_ID: n_bad_id++;
                default: ;
            endcase
            if (rsp_expected_q.size() == 0)
            begin
                $error("response transfer with no command outstanding");
                err_cnt++;
            end
            else
                check_rsp(rsp_expected_q.pop_front(), got);
        end
    end

    always @(negedge clk)
    begin : drive
        table_cmd_t nxt;
        bit         v_next;
        v_next = rst_n && cmd.valid && !cmd_fire;
        if (rst_n && !v_next && cmd_pending_q.size() > 0)
        begin
            if (!(cmd_pending_q[0].hold && rsp_expected_q.size() > 0) &&
                $urandom_range(0, 99) >= send_idle_pct)
            begin
                nxt = cmd_pending_q.pop_front();
                cmd.action   <= nxt.action;
                cmd.entry_id <= nxt.entry_id;
                cmd.payload  <= nxt.payload;
                v_next = 1'b1;
            end
        end
        cmd.valid <= v_next;
    end

    always @(negedge clk)
        rsp.ready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);

    task automatic push_cmd(input logic [ACT_W-1:0] a, input logic [ID_W-1:0] id,
                            input logic [DATA_W-1:0] d);
        table_cmd_t c;
        c.action   = a;
        c.entry_id = id;
        c.payload  = d;
        c.hold     = hold_next;
        hold_next  = 1'b0;
        cmd_pending_q.insert(cmd_pending_q.size(), c);
        if (a == ACT_ADD && live_count < NUM_SLOTS)
            live_count++;
        else if (a == ACT_POP_MAX && live_count > 0)
            live_count--;
    endtask

    function automatic logic [ID_W-1:0] pick_id();
        if (live_count > 0 && $urandom_range(0, 4) != 0)
            return ID_W'($urandom_range(0, live_count - 1));
        return ID_W'($urandom_range(0, NUM_SLOTS - 1));
    endfunction

    task automatic gen_phase(input int n_items);
        int made;
        int r;
        int n;
        made = 0;
        while (made < n_items)
        begin
            hold_next = ($urandom_range(0, 99) < 3);
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                n = NUM_SLOTS - live_count + $urandom_range(1, 3);
                repeat (n)
                    push_cmd(ACT_ADD, ID_W'($urandom), $urandom);
                made += n;
            end
            else if (r < 16)
            begin
                n = live_count + $urandom_range(1, 3);
                repeat (n)
                    push_cmd(ACT_POP_MAX, ID_W'($urandom), $urandom);
                made += n;
            end
            else
            begin
                n = $urandom_range(0, 6);
                repeat (n)
                    push_cmd(ACT_ADD, ID_W'($urandom), $urandom);
                made += n;
                n = $urandom_range(1, 10);
                repeat (n)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 40)
                        push_cmd(ACT_PROMOTE, pick_id(), $urandom);
                    else if (r < 55)
                        push_cmd(ACT_GET_MAX, ID_W'($urandom), $urandom);
                    else if (r < 65)
                        push_cmd(ACT_POP_MAX, ID_W'($urandom), $urandom);
                    else if (r < 75)
                        push_cmd(ACT_IS_VALID, pick_id(), $urandom);
                    else if (r < 88)
                        push_cmd(ACT_GET, pick_id(), $urandom);
                    else
                        push_cmd(ACT_W'($urandom_range(0, 7)), ID_W'($urandom), $urandom);
                end
                made += n;
            end
        end
    endtask

    task automatic wait_drained();
        while (cmd_pending_q.size() > 0 || rsp_expected_q.size() > 0 || cmd.valid)
            @(posedge clk);
    endtask

    initial
    begin : main
        cmd.valid    = 1'b0;
        cmd.action   = ACT_ADD;
        cmd.entry_id = '0;
        cmd.payload  = '0;
        rsp.ready    = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            slot_live[i] = 1'b0;
            slot_prio[i] = '0;
            slot_data[i] = '0;
            slot_tag[i]  = '0;
        end
        tag_next   = '0;
        err_cnt    = 0;
        cycle_cnt  = 0;
        n_cmds     = 0;
        n_rsps     = 0;
        n_full     = 0;
        n_empty    = 0;
        n_bad_id   = 0;
        live_count = 0;
        hold_next  = 1'b0;
        cmd_fire   = 1'b0;
        send_idle_pct = 16;
        recv_idle_pct = 46;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty table, free slots, ties, reuse of a freed slot
        push_cmd(ACT_GET_MAX, 6'd0, 32'h0);
        push_cmd(ACT_POP_MAX, 6'd63, 32'hFFFF_FFFF);
        push_cmd(ACT_PROMOTE, 6'd0, 32'h0);
        push_cmd(ACT_GET, 6'd63, 32'h0);
        push_cmd(ACT_IS_VALID, 6'd0, 32'h0);
        push_cmd(ACT_SPARE_6, 6'd63, 32'hFFFF_FFFF);
        push_cmd(ACT_ADD, 6'd63, 32'h0);
        push_cmd(ACT_ADD, 6'd0, 32'hFFFF_FFFF);
        push_cmd(ACT_IS_VALID, 6'd1, 32'h0);
        push_cmd(ACT_GET_MAX, 6'd0, 32'h0);
        push_cmd(ACT_PROMOTE, 6'd0, 32'h0);
        push_cmd(ACT_GET_MAX, 6'd0, 32'h0);
        push_cmd(ACT_GET, 6'd1, 32'h0);
        push_cmd(ACT_GET, 6'd0, 32'h0);
        push_cmd(ACT_POP_MAX, 6'd0, 32'h0);
        push_cmd(ACT_ADD, 6'd0, 32'h5A5A_5A5A);
        push_cmd(ACT_PROMOTE, 6'd1, 32'h0);
        push_cmd(ACT_PROMOTE, 6'd1, 32'h0);
        push_cmd(ACT_PROMOTE, 6'd0, 32'h0);
        push_cmd(ACT_GET_MAX, 6'd0, 32'h0);
        push_cmd(ACT_POP_MAX, 6'd0, 32'h0);
        push_cmd(ACT_POP_MAX, 6'd0, 32'h0);
        push_cmd(ACT_POP_MAX, 6'd0, 32'h0);
        push_cmd(ACT_SPARE_7, 6'd21, 32'hA5A5_A5A5);
        push_cmd(ACT_IS_VALID, 6'd63, 32'h0);

        // fill past capacity
        repeat (NUM_SLOTS + 2)
            push_cmd(ACT_ADD, ID_W'($urandom), $urandom);
        push_cmd(ACT_PROMOTE, 6'd63, 32'h0);
        push_cmd(ACT_IS_VALID, 6'd63, 32'h0);
        push_cmd(ACT_GET_MAX, 6'd0, 32'h0);
        push_cmd(ACT_POP_MAX, 6'd0, 32'h0);
        push_cmd(ACT_ADD, 6'd0, $urandom);
        push_cmd(ACT_GET, 6'd63, 32'h0);

        gen_phase(PHASE_ITEMS);
        wait_drained();

        send_idle_pct = 46;
        recv_idle_pct = 16;
        hold_next = 1'b1;
        gen_phase(PHASE_ITEMS);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        gen_phase(PHASE_ITEMS);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d commands and %0d responses; %0d full, %0d empty, %0d bad-id statuses",
                 n_cmds, n_rsps, n_full, n_empty, n_bad_id);
        $display("stall mixes covered: sender/receiver 16/46, 46/16 and none");
        if (err_cnt == 0 && rsp_expected_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
